[rtl/daisy_chain_sync_and_message_framer_unit_assert.svh]
`ifndef DAISY_CHAIN_SYNC_AND_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`define DAISY_CHAIN_SYNC_AND_MESSAGE_FRAMER_UNIT_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define DCSMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed in the same cycle");

// Checks that a condition holds in the cycle after its trigger.
`define DCSMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed one cycle later");

`endif

[rtl/dcsmf_pkg.sv]
package dcsmf_pkg;

    localparam int MSG_LEN = 15;
    localparam logic [7:0] SYNC_LEN = 8'd15;

    localparam int BYTE_W = 8;
    localparam int POS_W = 6;
    localparam int FILL_W = $clog2(MSG_LEN + 1);
    localparam int IDX_W = $clog2(MSG_LEN);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST = 8'd27;
    localparam logic [BYTE_W-1:0] BROADCAST_RST = 8'd255;

    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_MESSAGE = 1'b1;

    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic accept;
        logic idx_last;
    } dp_status_t;

endpackage

[rtl/daisy_chain_sync_and_message_framer_unit.sv]
// Channel        | Direction | Carries
// s_axis         | in        | tdata[7:0] rx_byte
// m_axis         | out       | tdata value, position, node_address; tuser kind; tlast last
// cfg            | in        | write of sync_byte (index 0) or broadcast_addr (index 1)
//
// A request that is only forwarded yields one forward item; an accepted message is then
// followed by its MSG_LEN message bytes, read one at a time from the message store, and
// no new request is taken until the last of them has been issued.
// Reset is asynchronous and needs no clearing pass; the message store is not reset.
// A stalled output holds its result register and stops new requests or message bytes.
module daisy_chain_sync_and_message_framer_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,  // rx_byte
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // value [7:0], position [13:8], node_address [21:14], zero [23:22]
    output logic [dcsmf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tuser,  // kind
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_we,
    input  logic [dcsmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dcsmf_pkg::BYTE_W-1:0]           cfg_data
);
    import dcsmf_pkg::*;

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic [BYTE_W-1:0]  out_value;
    logic [POS_W-1:0]   out_position;
    logic [BYTE_W-1:0]  out_address;

    dcsmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    dcsmf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rx_byte      (s_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_axis_tready),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_kind     (m_axis_tuser),
        .out_value    (out_value),
        .out_position (out_position),
        .out_address  (out_address),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 2 * BYTE_W - POS_W)'(0),
                           out_address, out_position, out_value};

`include "daisy_chain_sync_and_message_framer_unit_assert.svh"

    `DCSMF_ASSERT_NOW(a_ready_needs_room, s_axis_tready, !m_axis_tvalid || m_axis_tready)
    `DCSMF_ASSERT_NEXT(a_accept_blocks_input, s_axis_tvalid && s_axis_tready && status.accept, !s_axis_tready)
    `DCSMF_ASSERT_NOW(a_forward_position_zero, m_axis_tvalid && !m_axis_tuser, out_position == '0)
    `DCSMF_ASSERT_NOW(a_message_end_position, m_axis_tvalid && m_axis_tuser && m_axis_tlast, out_position == POS_W'(MSG_LEN - 1))

endmodule

[rtl/dcsmf_ctrl.sv]
module dcsmf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  dcsmf_pkg::dp_status_t status,
    output logic                  in_ready,
    output dcsmf_pkg::ctrl_cmd_t  cmd
);
    import dcsmf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MSG  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                cmd.step = in_valid && status.out_free;
                if (cmd.step && status.accept)
                begin
                    state_next = ST_MSG;
                end
            end
            ST_MSG:
            begin
                cmd.emit = status.out_free;
                if (cmd.emit && status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/dcsmf_dp.sv]
module dcsmf_dp (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  dcsmf_pkg::ctrl_cmd_t                      cmd,
    input  logic [dcsmf_pkg::BYTE_W-1:0]              rx_byte,
    input  logic                                      cfg_we,
    input  logic [dcsmf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [dcsmf_pkg::BYTE_W-1:0]              cfg_data,
    input  logic                                      out_ready,
    output dcsmf_pkg::dp_status_t                     status,
    output logic                                      out_valid,
    output logic                                      out_kind,
    output logic [dcsmf_pkg::BYTE_W-1:0]              out_value,
    output logic [dcsmf_pkg::POS_W-1:0]               out_position,
    output logic [dcsmf_pkg::BYTE_W-1:0]              out_address,
    output logic                                      out_last
);
    import dcsmf_pkg::*;

    logic [BYTE_W-1:0] sync_byte_reg;
    logic [BYTE_W-1:0] broadcast_reg;
    logic [BYTE_W-1:0] sync_run_reg;
    logic [BYTE_W-1:0] sync_run_next;
    logic [BYTE_W-1:0] own_addr_reg;
    logic [BYTE_W-1:0] own_addr_next;
    logic              synced_reg;
    logic              synced_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_after;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] store_reg [MSG_LEN];

    logic              is_addr;
    logic              store_en;
    logic              accept;
    logic [BYTE_W-1:0] fwd_byte;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic              out_kind_next;
    logic [BYTE_W-1:0] out_value_reg;
    logic [BYTE_W-1:0] out_value_next;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  out_pos_next;
    logic [BYTE_W-1:0] out_addr_reg;
    logic [BYTE_W-1:0] out_addr_next;
    logic              out_last_reg;
    logic              out_last_next;

    // The byte after a full sync run is taken as this node's address.
    always_comb
    begin
        is_addr       = (sync_run_reg == SYNC_LEN);
        store_en      = !is_addr && (fill_reg < FILL_W'(MSG_LEN));
        fwd_byte      = is_addr ? rx_byte + 8'd1 : rx_byte;
        own_addr_next = is_addr ? rx_byte : own_addr_reg;
        synced_next   = synced_reg || is_addr;
        sync_run_next = (rx_byte == sync_byte_reg) ? sync_run_reg + 8'd1 : '0;

        if (is_addr)
        begin
            fill_after = '0;
        end
        else if (store_en)
        begin
            fill_after = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_after = fill_reg;
        end

        accept = synced_next && (fill_after >= FILL_W'(MSG_LEN)) &&
                 ((store_reg[0] == own_addr_reg) || (store_reg[0] == broadcast_reg));
        fill_next = (synced_next && (fill_after >= FILL_W'(MSG_LEN))) ? '0 : fill_after;
    end

    always_comb
    begin
        status.out_free = !out_valid_reg || out_ready;
        status.accept   = accept;
        status.idx_last = (idx_reg == IDX_W'(MSG_LEN - 1));
    end

    always_comb
    begin
        if (cmd.step)
        begin
            out_kind_next  = KIND_FORWARD;
            out_value_next = fwd_byte;
            out_pos_next   = '0;
            out_addr_next  = own_addr_next;
            out_last_next  = !accept;
        end
        else
        begin
            out_kind_next  = KIND_MESSAGE;
            out_value_next = store_reg[idx_reg];
            out_pos_next   = POS_W'(idx_reg);
            out_addr_next  = own_addr_reg;
            out_last_next  = status.idx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_BYTE_RST;
            broadcast_reg <= BROADCAST_RST;
            sync_run_reg  <= '0;
            own_addr_reg  <= '0;
            synced_reg    <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SYNC_BYTE: sync_byte_reg <= cfg_data;
                    REG_BROADCAST: broadcast_reg <= cfg_data;
                    default:       sync_byte_reg <= sync_byte_reg;
                endcase
            end

            if (cmd.step)
            begin
                sync_run_reg <= sync_run_next;
                own_addr_reg <= own_addr_next;
                synced_reg   <= synced_next;
                fill_reg     <= fill_next;
                idx_reg      <= '0;
            end
            else if (cmd.emit)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.step || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && store_en)
        begin
            store_reg[fill_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.step || cmd.emit)
        begin
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
            out_pos_reg   <= out_pos_next;
            out_addr_reg  <= out_addr_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_pos_reg;
    assign out_address  = out_addr_reg;
    assign out_last     = out_last_reg;

endmodule
